/* sv/utkn_pkg.sv */
// Shared types and constants of the UTF-8 text key normalizer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package utkn_pkg;

    // Depth of the byte queue between front and back.
    localparam int UTKN_QUEUE_DEPTH = 4;
    // Longest UTF-8 sequence, and so the depth of the pending byte buffer.
    localparam int UTKN_BUF_DEPTH   = 4;

    // Byte classes, as seen from the lead position of a sequence.
    typedef enum logic [2:0] {
        LC_ASCII,
        LC_LEAD2,
        LC_LEAD3,
        LC_LEAD4,
        LC_CONT,
        LC_BAD
    } utkn_cls_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_RUN,
        BS_FLUSH
    } utkn_bstate_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_end;
    } utkn_in_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       char_valid;
        logic       line_done;
    } utkn_out_t;

    typedef struct packed {
        logic [7:0] data;
        utkn_cls_t  cls;
    } utkn_byte_t;

    typedef struct packed {
        utkn_byte_t ub;
        logic       line_end;
    } utkn_qent_t;

    // Emitted characters.
    localparam logic [6:0] CH_NONE  = 7'h00;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_C     = 7'h63;
    localparam logic [6:0] CH_E     = 7'h65;
    localparam logic [6:0] CH_I     = 7'h69;
    localparam logic [6:0] CH_N     = 7'h6E;
    localparam logic [6:0] CH_O     = 7'h6F;
    localparam logic [6:0] CH_U     = 7'h75;
    localparam logic [6:0] CH_Y     = 7'h79;

endpackage

`default_nettype wire

/* sv/utf8_text_key_normalizer_top.sv */
// Top level of the UTF-8 text key normalizer: front classifier, byte queue, back decoder.
// Depends on utkn_pkg, utkn_front, utkn_queue and utkn_back.
//
//   port group      dir   handshake          payload
//   s_ (bytes in)   in    s_valid/s_ready    s_data: in_byte, line_end
//   m_ (key out)    out   m_valid/m_ready    m_data: out_char, char_valid, line_done
//
// A byte that completes a sequence, or leaves one waiting, takes a single decode step in
// the back decoder, so plain text streams at one byte per cycle while m_ready keeps up.
// The back decoder holds off the queue while it sends an owed space ahead of a letter,
// while it re-decodes after a bad continuation byte, and when the last decode step of a
// line-end byte emits a character while an earlier result is held.
// Reset (aresetn low at a clock edge) empties queue and buffer and starts a new line.
// The queue lets the front keep taking bytes while the back waits on m_ready.
`default_nettype none

module utf8_text_key_normalizer_top #(
    parameter int QUEUE_DEPTH = utkn_pkg::UTKN_QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire utkn_pkg::utkn_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output utkn_pkg::utkn_out_t     m_data
);
    import utkn_pkg::*;

    // front to queue: classified bytes
    logic       fq_valid, fq_ready;
    utkn_qent_t fq_data;
    // queue to back
    logic       qb_valid, qb_ready;
    utkn_qent_t qb_data;

    // tag each byte with its UTF-8 class
    utkn_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    // hold bytes while the back drains owed spaces or re-decodes
    utkn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // decode, fold, collapse spaces and mark line ends; registered output
    utkn_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* sv/utkn_front.sv */
// Front of the normalizer: takes input items and tags each byte with its UTF-8 class.
// Depends on utkn_pkg.
`default_nettype none

module utkn_front (
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire utkn_pkg::utkn_in_t s_data,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output utkn_pkg::utkn_qent_t    q_data
);
    import utkn_pkg::*;

    utkn_cls_t cls;

    always_comb begin
        priority if (s_data.in_byte[7] == 1'b0) begin
            cls = LC_ASCII;
        end else if (s_data.in_byte[7:6] == 2'b10) begin
            cls = LC_CONT;
        end else if (s_data.in_byte[7:5] == 3'b110) begin
            cls = LC_LEAD2;
        end else if (s_data.in_byte[7:4] == 4'b1110) begin
            cls = LC_LEAD3;
        end else if (s_data.in_byte[7:3] == 5'b11110) begin
            cls = LC_LEAD4;
        end else begin
            cls = LC_BAD;
        end
    end

    assign q_valid          = s_valid;
    assign s_ready          = q_ready;
    assign q_data.ub.data   = s_data.in_byte;
    assign q_data.ub.cls    = cls;
    assign q_data.line_end  = s_data.line_end;

endmodule

`default_nettype wire

/* sv/utkn_queue.sv */
// Register queue of classified bytes between front and back.
// Depends on utkn_pkg.
`default_nettype none

module utkn_queue #(
    parameter int DEPTH = utkn_pkg::UTKN_QUEUE_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_valid,
    output logic                      wr_ready,
    input  wire utkn_pkg::utkn_qent_t wr_data,
    output logic                      rd_valid,
    input  wire logic                 rd_ready,
    output utkn_pkg::utkn_qent_t      rd_data
);
    import utkn_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utkn_qent_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg == $past(count_reg) + CNT_W'($past(push)) - CNT_W'($past(pop)))
        else $error("queue count out of step with handshakes");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

/* sv/utkn_back.sv */
// Back of the normalizer: pending byte buffer, sequence decoder, folding,
// space collapsing and line-end marking; one decode step per unstalled cycle.
// Depends on utkn_pkg.
`default_nettype none

module utkn_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire utkn_pkg::utkn_qent_t q_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output utkn_pkg::utkn_out_t       m_data
);
    import utkn_pkg::*;

    localparam int IDX_W = $clog2(UTKN_BUF_DEPTH);
    localparam int CNT_W = $clog2(UTKN_BUF_DEPTH + 1);

    localparam logic [20:0] CP_SOFT_HYPHEN = 21'h0000AD;
    localparam logic [20:0] CP_ZW_SPACE    = 21'h00200B;
    localparam logic [20:0] CP_BOM         = 21'h00FEFF;
    localparam logic [6:0]  CASE_OFFSET    = 7'h20;

    function automatic logic [6:0] fold_cp(input logic [20:0] cp);
        logic [7:0] u;
        logic [6:0] ch;
        u = cp[7:0] | 8'h20;
        priority if (cp == CP_SOFT_HYPHEN || cp == CP_ZW_SPACE || cp == CP_BOM) begin
            ch = CH_NONE;
        end else if (cp >= 21'h41 && cp <= 21'h5A) begin
            ch = cp[6:0] + CASE_OFFSET;
        end else if ((cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h30 && cp <= 21'h39)) begin
            ch = cp[6:0];
        end else if (cp < 21'hC0 || cp > 21'hFF) begin
            ch = CH_SPACE;
        end else if (cp == 21'hFF) begin
            ch = CH_Y;
        end else if (u >= 8'hE0 && u <= 8'hE5) begin
            ch = CH_A;
        end else if (u == 8'hE7) begin
            ch = CH_C;
        end else if (u >= 8'hE8 && u <= 8'hEB) begin
            ch = CH_E;
        end else if (u >= 8'hEC && u <= 8'hEF) begin
            ch = CH_I;
        end else if (u == 8'hF1) begin
            ch = CH_N;
        end else if (u >= 8'hF2 && u <= 8'hF6) begin
            ch = CH_O;
        end else if (u >= 8'hF9 && u <= 8'hFC) begin
            ch = CH_U;
        end else if (u == 8'hFD) begin
            ch = CH_Y;
        end else begin
            ch = CH_SPACE;
        end
        return ch;
    endfunction

    utkn_bstate_t     state_reg, state_next;
    utkn_byte_t       buf_reg [UTKN_BUF_DEPTH];
    utkn_byte_t       buf_next [UTKN_BUF_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             owed_reg, owed_next;
    logic             start_reg, start_next;
    logic             end_reg, end_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [6:0]       hold_char_reg, hold_char_next;
    logic             out_valid_reg, out_valid_next;
    utkn_out_t        out_reg, out_next;

    // working view of the buffer, with the incoming byte appended
    utkn_byte_t       wb [UTKN_BUF_DEPTH];
    utkn_byte_t       shifted [UTKN_BUF_DEPTH];
    logic [CNT_W-1:0] wcnt;
    logic             wend;
    logic [IDX_W-1:0] ins_idx;
    logic             take, active, flushing;

    // decode step
    logic [CNT_W-1:0] seq_len, drop, cnt_after;
    logic             bad_lead, incomplete, cont_bad;
    logic [20:0]      cp;
    logic [6:0]       sym, em_char;
    logic             is_letter, split, consume, finish, em_valid;
    logic             owed_feed, start_feed;

    // result routing
    logic             push, stall, out_free, advance;
    logic             hold_load, hold_clear, go_flush;
    utkn_out_t        push_data;

    assign ins_idx  = cnt_reg[IDX_W] ? '0 : cnt_reg[IDX_W-1:0];
    assign take     = (state_reg == BS_IDLE) && q_valid;
    assign active   = take || (state_reg == BS_RUN);
    assign flushing = (state_reg == BS_FLUSH);
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        for (int i = 0; i < UTKN_BUF_DEPTH; i++) begin
            wb[i] = buf_reg[i];
        end
        wcnt = cnt_reg;
        wend = end_reg;
        if (take) begin
            wb[ins_idx] = q_data.ub;
            wcnt        = CNT_W'(ins_idx) + CNT_W'(1);
            wend        = q_data.line_end;
        end
    end

    // one decode step on the head of the buffer
    always_comb begin
        bad_lead = (wb[0].cls == LC_CONT) || (wb[0].cls == LC_BAD);
        unique case (wb[0].cls)
            LC_ASCII: begin
                seq_len = CNT_W'(1);
                cp      = {14'b0, wb[0].data[6:0]};
            end
            LC_LEAD2: begin
                seq_len = CNT_W'(2);
                cp      = {10'b0, wb[0].data[4:0], wb[1].data[5:0]};
            end
            LC_LEAD3: begin
                seq_len = CNT_W'(3);
                cp      = {5'b0, wb[0].data[3:0], wb[1].data[5:0], wb[2].data[5:0]};
            end
            LC_LEAD4: begin
                seq_len = CNT_W'(4);
                cp      = {wb[0].data[2:0], wb[1].data[5:0], wb[2].data[5:0],
                           wb[3].data[5:0]};
            end
            default: begin
                seq_len = CNT_W'(1);
                cp      = '0;
            end
        endcase

        incomplete = !bad_lead && (wcnt < seq_len);
        cont_bad   = 1'b0;
        for (int k = 1; k < UTKN_BUF_DEPTH; k++) begin
            if ((CNT_W'(k) < seq_len) && (wb[k].cls != LC_CONT)) begin
                cont_bad = 1'b1;
            end
        end

        priority if (bad_lead) begin
            sym  = CH_SPACE;
            drop = CNT_W'(1);
        end else if (incomplete) begin
            sym  = wend ? CH_SPACE : CH_NONE;
            drop = '0;
        end else if (cont_bad) begin
            sym  = CH_SPACE;
            drop = CNT_W'(1);
        end else begin
            sym  = fold_cp(cp);
            drop = seq_len;
        end

        if (incomplete) begin
            cnt_after = wend ? '0 : wcnt;
        end else begin
            cnt_after = wcnt - drop;
        end

        for (int i = 0; i < UTKN_BUF_DEPTH; i++) begin
            shifted[i] = wb[i];
            if (i + int'(drop) < UTKN_BUF_DEPTH) begin
                shifted[i] = wb[IDX_W'(i + int'(drop))];
            end
        end

        // collapse spaces; an owed space goes out ahead of its letter
        is_letter  = (sym != CH_NONE) && (sym != CH_SPACE);
        split      = is_letter && owed_reg;
        consume    = !split;
        em_valid   = is_letter;
        em_char    = split ? CH_SPACE : sym;
        owed_feed  = owed_reg;
        start_feed = start_reg;
        if (sym == CH_SPACE) begin
            if (!start_reg) begin
                owed_feed = 1'b1;
            end
        end else if (is_letter) begin
            owed_feed = 1'b0;
            if (!split) begin
                start_feed = 1'b0;
            end
        end
        finish = consume && (incomplete || (cnt_after == '0));
    end

    // route results; on a line end the newest result waits in hold so that
    // it can carry line_done
    always_comb begin
        push       = 1'b0;
        push_data  = '{out_char: em_char, char_valid: 1'b1, line_done: 1'b0};
        hold_load  = 1'b0;
        hold_clear = 1'b0;
        go_flush   = 1'b0;
        if (flushing) begin
            push       = 1'b1;
            push_data  = '{out_char: hold_char_reg, char_valid: 1'b1, line_done: 1'b1};
            hold_clear = 1'b1;
        end else if (active) begin
            if (!wend) begin
                push = em_valid;
            end else if (em_valid) begin
                if (hold_valid_reg) begin
                    push      = 1'b1;
                    push_data = '{out_char: hold_char_reg, char_valid: 1'b1, line_done: 1'b0};
                    hold_load = 1'b1;
                    go_flush  = finish;
                end else if (finish) begin
                    push      = 1'b1;
                    push_data = '{out_char: em_char, char_valid: 1'b1, line_done: 1'b1};
                end else begin
                    hold_load = 1'b1;
                end
            end else if (finish) begin
                push = 1'b1;
                if (hold_valid_reg) begin
                    push_data  = '{out_char: hold_char_reg, char_valid: 1'b1,
                                   line_done: 1'b1};
                    hold_clear = 1'b1;
                end else begin
                    push_data  = '{out_char: CH_NONE, char_valid: 1'b0, line_done: 1'b1};
                end
            end
        end
    end

    assign stall   = push && !out_free;
    assign advance = (active || flushing) && !stall;
    assign q_ready = take && !stall;

    // next state
    always_comb begin
        state_next = state_reg;
        if (!stall) begin
            unique case (state_reg)
                BS_IDLE: begin
                    if (take) begin
                        if (!finish) begin
                            state_next = BS_RUN;
                        end else if (go_flush) begin
                            state_next = BS_FLUSH;
                        end
                    end
                end
                BS_RUN: begin
                    if (finish) begin
                        state_next = go_flush ? BS_FLUSH : BS_IDLE;
                    end
                end
                BS_FLUSH: begin
                    state_next = BS_IDLE;
                end
                default: begin
                    state_next = BS_IDLE;
                end
            endcase
        end
    end

    // datapath and flag updates
    always_comb begin
        for (int i = 0; i < UTKN_BUF_DEPTH; i++) begin
            buf_next[i] = buf_reg[i];
        end
        cnt_next        = cnt_reg;
        owed_next       = owed_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        hold_valid_next = hold_valid_reg;
        hold_char_next  = hold_char_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (advance && active) begin
            for (int i = 0; i < UTKN_BUF_DEPTH; i++) begin
                buf_next[i] = consume ? shifted[i] : wb[i];
            end
            cnt_next   = consume ? cnt_after : wcnt;
            owed_next  = owed_feed;
            start_next = start_feed;
            end_next   = wend;
            if (finish && wend) begin
                cnt_next   = '0;
                owed_next  = 1'b0;
                start_next = 1'b1;
            end
        end
        if (advance) begin
            if (hold_load) begin
                hold_valid_next = 1'b1;
                hold_char_next  = em_char;
            end else if (hold_clear) begin
                hold_valid_next = 1'b0;
            end
        end

        if (push && !stall) begin
            out_valid_next = 1'b1;
            out_next       = push_data;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BS_IDLE;
            cnt_reg        <= '0;
            owed_reg       <= 1'b0;
            start_reg      <= 1'b1;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            owed_reg       <= owed_next;
            start_reg      <= start_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < UTKN_BUF_DEPTH; i++) begin
            buf_reg[i] <= buf_next[i];
        end
        end_reg       <= end_next;
        hold_char_reg <= hold_char_next;
        out_reg       <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BS_IDLE) |-> (cnt_reg <= CNT_W'(UTKN_BUF_DEPTH - 1)))
        else $error("buffer holds a complete sequence while idle");

    a_line_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && active && finish && wend) |=>
            (start_reg && !owed_reg && (cnt_reg == '0)))
        else $error("line state not cleared after line end");

    a_hold_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (end_reg && (state_reg != BS_IDLE)))
        else $error("held result outside a line-end step");

    a_owed_start: assert property (@(posedge aclk) disable iff (!aresetn)
        owed_reg |-> !start_reg)
        else $error("space owed at line start");

    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.char_valid) |->
            (out_reg.line_done && (out_reg.out_char == CH_NONE)))
        else $error("bare marker malformed");

endmodule

`default_nettype wire
